/* src/dkoc_pkg.sv */
// dkoc_pkg: shared widths, codes and beat types of the dark offset calibration block
// no dependencies; imported by every module under src

package dkoc_pkg;

  // capacity per frame
  localparam int MAX_PIXELS = 4096;

  localparam int NUM_CH   = 3;
  localparam int CH_W     = 2;
  localparam int PIX_W    = 16;
  localparam int CODE_W   = 16;
  localparam int MARGIN_W = 12;

  // offset bracket: low frame at 0x80, high frame at 0xff
  localparam int BRACKET_LO = 'h80;
  localparam int BRACKET_HI = 'hFF;
  localparam int SPAN       = BRACKET_HI - BRACKET_LO;
  localparam int SPAN_W     = 7;

  // accumulator and product widths
  localparam int CNT_W   = $clog2(MAX_PIXELS + 1);
  localparam int SUM_W   = PIX_W + $clog2(MAX_PIXELS);
  localparam int P_W     = 2 * CNT_W;
  localparam int P127_W  = P_W + SPAN_W;
  localparam int POS_W   = SUM_W + CNT_W;
  localparam int NUM_W   = MARGIN_W + P127_W;
  // quotient never exceeds the margin since the slope is at least one
  localparam int Q_W       = MARGIN_W;
  localparam int DS_W      = POS_W + Q_W - 1;
  localparam int DIV_CNT_W = $clog2(Q_W);

  // shared multiplier
  localparam int MUL_A_W = (SUM_W > P127_W) ? SUM_W : P127_W;
  localparam int MUL_B_W = (CNT_W > MARGIN_W) ? CNT_W : MARGIN_W;
  localparam int MUL_W   = MUL_A_W + MUL_B_W;

  // action codes
  localparam logic [1:0] ACT_LOW    = 2'd0;
  localparam logic [1:0] ACT_HIGH   = 2'd1;
  localparam logic [1:0] ACT_FINISH = 2'd2;
  localparam logic [1:0] ACT_NONE   = 2'd3;

  // configuration register map
  localparam int REG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [REG_IDX_W-1:0] REG_MARGIN_RED    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_MARGIN_GREEN  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MARGIN_BLUE   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DEFAULT_RED   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_DEFAULT_GREEN = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_DEFAULT_BLUE  = 3'd5;

  localparam logic [MARGIN_W-1:0] RST_MARGIN_RED    = 12'd211;
  localparam logic [MARGIN_W-1:0] RST_MARGIN_GREEN  = 12'd198;
  localparam logic [MARGIN_W-1:0] RST_MARGIN_BLUE   = 12'd215;
  localparam logic [CODE_W-1:0]   RST_DEFAULT_RED   = 16'h010B;
  localparam logic [CODE_W-1:0]   RST_DEFAULT_GREEN = 16'h010A;
  localparam logic [CODE_W-1:0]   RST_DEFAULT_BLUE  = 16'h010B;

  typedef struct packed {
    logic [1:0]       action;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } in_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] code_red;
    logic [CODE_W-1:0] code_green;
    logic [CODE_W-1:0] code_blue;
    logic              fallback_red;
    logic              fallback_green;
    logic              fallback_blue;
    logic              overflow;
  } out_item_t;

  typedef logic [NUM_CH-1:0][MARGIN_W-1:0] margin_arr_t;
  typedef logic [NUM_CH-1:0][CODE_W-1:0]   code_arr_t;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_PROD,
    OP_POS,
    OP_NEG,
    OP_NUM,
    OP_CMP,
    OP_DIV,
    OP_RND,
    OP_COMMIT
  } op_e;

  typedef struct packed {
    op_e             op;
    logic [CH_W-1:0] ch;
    logic            acc_en;
    logic            acc_hi;
  } cmd_t;

  typedef struct packed {
    logic fallback;
    logic out_free;
  } status_t;

endpackage

/* src/dark_offset_calibration.sv */
// dark_offset_calibration: top level with configuration registers
// depends on dkoc_pkg, dkoc_ctrl and dkoc_datapath

// Two-point dark offset calibration. Pixel beats (action low or high frame) are taken one
// per cycle whenever the block is idle: each adds its red, green and blue samples to that
// frame's sums, up to 4096 pixels per frame, beyond which pixels are dropped and the
// overflow bit of the next result is set. A finish beat stalls the input while a sequencer
// works through the three channels on one shared 33x13 multiplier and a restoring divider
// that yields one quotient bit a cycle: the product of the pixel counts, then per channel
// the cross products, numerator and slope compare, then the default code with fallback set
// if the slope is below one, else division and rounding. The stall lasts until any previous
// result has been taken. The code is 255 + round-half-even(margin / slope), saturated to
// 16 bits. The result sits in an output register, so pixel beats of the next calibration
// are accepted while it waits. Finish clears sums, counts and the overflow flag; action 3
// is taken and ignored. The configuration port is always ready; indexes 6 and 7 are ignored.

module dark_offset_calibration (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // pixel and finish beats
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  dkoc_pkg::in_item_t                  in_data_i,
  // result beats
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output dkoc_pkg::out_item_t                 out_data_o,
  // register writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [dkoc_pkg::REG_IDX_W-1:0]      cfg_index_i,
  input  logic [dkoc_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import dkoc_pkg::*;

  margin_arr_t margin_q;
  code_arr_t   dflt_q;
  cmd_t        cmd;
  status_t     status;

  // no back pressure on register writes
  assign cfg_ready_o = 1'b1;

  // register file, each write masked to the register width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q[0] <= RST_MARGIN_RED;
      margin_q[1] <= RST_MARGIN_GREEN;
      margin_q[2] <= RST_MARGIN_BLUE;
      dflt_q[0]   <= RST_DEFAULT_RED;
      dflt_q[1]   <= RST_DEFAULT_GREEN;
      dflt_q[2]   <= RST_DEFAULT_BLUE;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_MARGIN_RED:    margin_q[0] <= cfg_data_i[MARGIN_W-1:0];
        REG_MARGIN_GREEN:  margin_q[1] <= cfg_data_i[MARGIN_W-1:0];
        REG_MARGIN_BLUE:   margin_q[2] <= cfg_data_i[MARGIN_W-1:0];
        REG_DEFAULT_RED:   dflt_q[0]   <= cfg_data_i[CODE_W-1:0];
        REG_DEFAULT_GREEN: dflt_q[1]   <= cfg_data_i[CODE_W-1:0];
        REG_DEFAULT_BLUE:  dflt_q[2]   <= cfg_data_i[CODE_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer: accepts beats while idle, steps through products, compare and divide
  dkoc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_action_i (in_data_i.action),
    .in_stall_o  (in_stall_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // accumulators, arithmetic and output register
  dkoc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .margin_i    (margin_q),
    .dflt_i      (dflt_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* src/dkoc_ctrl.sv */
// dkoc_ctrl: sequencer of the finish computation, channel and division step counters
// depends on dkoc_pkg; drives dkoc_datapath through cmd_t

module dkoc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        in_action_i,
  output logic              in_stall_o,
  input  dkoc_pkg::status_t status_i,
  output dkoc_pkg::cmd_t    cmd_o
);
  import dkoc_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PROD = 4'd1;
  localparam logic [3:0] S_POS  = 4'd2;
  localparam logic [3:0] S_NEG  = 4'd3;
  localparam logic [3:0] S_NUM  = 4'd4;
  localparam logic [3:0] S_CMP  = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_RND  = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0]           state_q, state_d;
  logic [CH_W-1:0]      ch_q, ch_d;
  logic [DIV_CNT_W-1:0] step_q, step_d;
  logic                 accept;
  logic                 last_ch;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign last_ch    = (ch_q == CH_W'(NUM_CH - 1));

  always_comb begin
    state_d      = state_q;
    ch_d         = ch_q;
    step_d       = step_q;
    cmd_o.op     = OP_NONE;
    cmd_o.ch     = ch_q;
    cmd_o.acc_en = accept && ((in_action_i == ACT_LOW) || (in_action_i == ACT_HIGH));
    cmd_o.acc_hi = (in_action_i == ACT_HIGH);
    unique case (state_q)
      S_IDLE: begin
        if (accept && (in_action_i == ACT_FINISH)) begin
          state_d = S_PROD;
          ch_d    = '0;
        end
      end
      S_PROD: begin
        cmd_o.op = OP_PROD;
        state_d  = S_POS;
      end
      S_POS: begin
        cmd_o.op = OP_POS;
        state_d  = S_NEG;
      end
      S_NEG: begin
        cmd_o.op = OP_NEG;
        state_d  = S_NUM;
      end
      S_NUM: begin
        cmd_o.op = OP_NUM;
        state_d  = S_CMP;
      end
      S_CMP: begin
        cmd_o.op = OP_CMP;
        if (status_i.fallback) begin
          if (last_ch) begin
            state_d = S_DONE;
          end else begin
            ch_d    = ch_q + CH_W'(1);
            state_d = S_POS;
          end
        end else begin
          step_d  = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.op = OP_DIV;
        step_d   = step_q + DIV_CNT_W'(1);
        if (step_q == DIV_CNT_W'(Q_W - 1)) begin
          state_d = S_RND;
        end
      end
      S_RND: begin
        cmd_o.op = OP_RND;
        if (last_ch) begin
          state_d = S_DONE;
        end else begin
          ch_d    = ch_q + CH_W'(1);
          state_d = S_POS;
        end
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.op = OP_COMMIT;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ch_q    <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
      step_q  <= step_d;
    end
  end

endmodule

/* src/dkoc_datapath.sv */
// dkoc_datapath: frame accumulators, shared multiplier, restoring divider, result register
// depends on dkoc_pkg; commanded by dkoc_ctrl

module dkoc_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dkoc_pkg::cmd_t        cmd_i,
  output dkoc_pkg::status_t     status_o,
  input  dkoc_pkg::in_item_t    in_data_i,
  input  dkoc_pkg::margin_arr_t margin_i,
  input  dkoc_pkg::code_arr_t   dflt_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output dkoc_pkg::out_item_t   out_data_o
);
  import dkoc_pkg::*;

  logic [NUM_CH-1:0][SUM_W-1:0] lo_sum_q, hi_sum_q;
  logic [CNT_W-1:0]             lo_cnt_q, hi_cnt_q;
  logic                         drop_q;
  logic [NUM_CH-1:0][PIX_W-1:0] px;

  logic [P_W-1:0]    p_q;
  logic [POS_W-1:0]  pos_q, neg_q, d_q, diff;
  logic [NUM_W-1:0]  num_q, rem_q;
  logic [DS_W-1:0]   ds_q;
  logic [Q_W-1:0]    q_q;
  code_arr_t         code_q;
  logic [NUM_CH-1:0] fb_q;
  out_item_t         out_q;
  logic              out_valid_q;

  logic [CNT_W-1:0]   lo_eff, hi_eff;
  logic [P127_W-1:0]  p127;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_W-1:0]   prod;
  logic               ge;
  logic [NUM_W:0]     twice_r, d_ext;
  logic               up;
  logic [Q_W:0]       q_rnd;
  logic [CODE_W:0]    code_sum;
  logic [CODE_W-1:0]  code_sat;

  assign px = {in_data_i.blue, in_data_i.green, in_data_i.red};

  // an empty frame counts as one pixel of sum zero
  assign lo_eff = (lo_cnt_q == '0) ? CNT_W'(1) : lo_cnt_q;
  assign hi_eff = (hi_cnt_q == '0) ? CNT_W'(1) : hi_cnt_q;
  assign p127   = P127_W'(p_q) * P127_W'(SPAN);

  always_comb begin
    case (cmd_i.op)
      OP_PROD: begin
        mul_a = MUL_A_W'(lo_eff);
        mul_b = MUL_B_W'(hi_eff);
      end
      OP_POS: begin
        mul_a = MUL_A_W'(hi_sum_q[cmd_i.ch]);
        mul_b = MUL_B_W'(lo_eff);
      end
      OP_NEG: begin
        mul_a = MUL_A_W'(lo_sum_q[cmd_i.ch]);
        mul_b = MUL_B_W'(hi_eff);
      end
      default: begin
        mul_a = MUL_A_W'(p127);
        mul_b = MUL_B_W'(margin_i[cmd_i.ch]);
      end
    endcase
  end

  assign prod = MUL_W'(mul_a) * MUL_W'(mul_b);

  // slope below one when pos < neg + 127 * p
  assign status_o.fallback = ({1'b0, pos_q} < ({1'b0, neg_q} + (POS_W + 1)'(p127)));
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  assign diff = pos_q - neg_q;
  assign ge   = (DS_W'(rem_q) >= ds_q);

  // round half to even
  assign twice_r  = {rem_q, 1'b0};
  assign d_ext    = (NUM_W + 1)'(d_q);
  assign up       = (twice_r > d_ext) || ((twice_r == d_ext) && q_q[0]);
  assign q_rnd    = {1'b0, q_q} + (Q_W + 1)'(up);
  assign code_sum = (CODE_W + 1)'(BRACKET_HI) + (CODE_W + 1)'(q_rnd);
  assign code_sat = code_sum[CODE_W] ? {CODE_W{1'b1}} : code_sum[CODE_W-1:0];

  // accumulators and overflow flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_sum_q <= '0;
      hi_sum_q <= '0;
      lo_cnt_q <= '0;
      hi_cnt_q <= '0;
      drop_q   <= 1'b0;
    end else if (cmd_i.op == OP_COMMIT) begin
      lo_sum_q <= '0;
      hi_sum_q <= '0;
      lo_cnt_q <= '0;
      hi_cnt_q <= '0;
      drop_q   <= 1'b0;
    end else if (cmd_i.acc_en) begin
      if (cmd_i.acc_hi) begin
        if (hi_cnt_q >= CNT_W'(MAX_PIXELS)) begin
          drop_q <= 1'b1;
        end else begin
          for (int c = 0; c < NUM_CH; c++) begin
            hi_sum_q[c] <= hi_sum_q[c] + SUM_W'(px[c]);
          end
          hi_cnt_q <= hi_cnt_q + CNT_W'(1);
        end
      end else begin
        if (lo_cnt_q >= CNT_W'(MAX_PIXELS)) begin
          drop_q <= 1'b1;
        end else begin
          for (int c = 0; c < NUM_CH; c++) begin
            lo_sum_q[c] <= lo_sum_q[c] + SUM_W'(px[c]);
          end
          lo_cnt_q <= lo_cnt_q + CNT_W'(1);
        end
      end
    end
  end

  // products, divider and per-channel codes
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_PROD: p_q   <= prod[P_W-1:0];
      OP_POS:  pos_q <= prod[POS_W-1:0];
      OP_NEG:  neg_q <= prod[POS_W-1:0];
      OP_NUM:  num_q <= prod[NUM_W-1:0];
      OP_CMP: begin
        if (status_o.fallback) begin
          code_q[cmd_i.ch] <= dflt_i[cmd_i.ch];
          fb_q[cmd_i.ch]   <= 1'b1;
        end else begin
          d_q   <= diff;
          rem_q <= num_q;
          ds_q  <= {diff, {(Q_W - 1){1'b0}}};
          q_q   <= '0;
        end
      end
      OP_DIV: begin
        q_q  <= {q_q[Q_W-2:0], ge};
        ds_q <= ds_q >> 1;
        if (ge) begin
          rem_q <= rem_q - NUM_W'(ds_q);
        end
      end
      OP_RND: begin
        code_q[cmd_i.ch] <= code_sat;
        fb_q[cmd_i.ch]   <= 1'b0;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_COMMIT) begin
      out_q.code_red       <= code_q[0];
      out_q.code_green     <= code_q[1];
      out_q.code_blue      <= code_q[2];
      out_q.fallback_red   <= fb_q[0];
      out_q.fallback_green <= fb_q[1];
      out_q.fallback_blue  <= fb_q[2];
      out_q.overflow       <= drop_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_COMMIT) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lo_cnt_q <= CNT_W'(MAX_PIXELS)) && (hi_cnt_q <= CNT_W'(MAX_PIXELS)))
    else $error("frame count above capacity");

  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drop_q |-> ((lo_cnt_q == CNT_W'(MAX_PIXELS)) || (hi_cnt_q == CNT_W'(MAX_PIXELS))))
    else $error("drop flag without a full frame");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_RND) |-> (rem_q < NUM_W'(d_q)))
    else $error("division remainder not below divisor");

  a_commit_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_COMMIT) |=> (lo_cnt_q == '0) && (hi_cnt_q == '0) && !drop_q && out_valid_q)
    else $error("finish did not clear accumulators or raise result");

  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_COMMIT) |-> (!out_valid_q || !out_stall_i))
    else $error("result overwritten while stalled");
`endif

endmodule

/* verif/tb_dark_offset_calibration.sv */
// tb_dark_offset_calibration: self-checking testbench of the dark offset calibration block
// depends on dkoc_pkg and dark_offset_calibration from src

module tb_dark_offset_calibration;
  import dkoc_pkg::*;

  localparam int CLK_HALF      = 10;
  localparam int RESET_CYCLES  = 10;
  // a whole finish sequence inside the block fits within the settle time
  localparam int SETTLE_CYCLES = 60;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int RANDOM_BEATS  = 1200;
  localparam int NUM_PHASES    = 6;
  localparam int HOLD_CYCLES   = 400;

  // register indexes past the map, written to see them ignored
  localparam logic [REG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  // one row of the directed part: the beat, and where obvious the typed-in result
  typedef struct packed {
    in_item_t  beat;
    logic      typed;
    out_item_t want;
  } dir_row_t;

  localparam out_item_t ALL_DEFAULTS = '{RST_DEFAULT_RED, RST_DEFAULT_GREEN, RST_DEFAULT_BLUE,
                                         1'b1, 1'b1, 1'b1, 1'b0};
  localparam out_item_t NO_TYPED     = '0;

  localparam dir_row_t DIRECTED [25] = '{
    // finish right after reset: both frames empty, slope zero, defaults everywhere
    '{'{ACT_FINISH, 16'h0000, 16'h0000, 16'h0000}, 1'b1, ALL_DEFAULTS},
    // full-scale step: slope far above one, quotient rounds to zero
    '{'{ACT_LOW,    16'h0000, 16'h0000, 16'h0000}, 1'b0, NO_TYPED},
    '{'{ACT_HIGH,   16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, NO_TYPED},
    '{'{ACT_FINISH, 16'h0000, 16'h0000, 16'h0000}, 1'b1,
      '{16'd255, 16'd255, 16'd255, 1'b0, 1'b0, 1'b0, 1'b0}},
    // falling step: negative slope takes the defaults
    '{'{ACT_LOW,    16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, NO_TYPED},
    '{'{ACT_HIGH,   16'h0000, 16'h0000, 16'h0000}, 1'b0, NO_TYPED},
    '{'{ACT_FINISH, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1, ALL_DEFAULTS},
    // unused action is dropped without a trace
    '{'{ACT_NONE,   16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, NO_TYPED},
    // slope exactly one gives the margin itself on red and green, just below on blue
    '{'{ACT_LOW,    16'h0000, 16'h0000, 16'h0000}, 1'b0, NO_TYPED},
    '{'{ACT_HIGH,   16'd127,  16'd127,  16'd126},  1'b0, NO_TYPED},
    '{'{ACT_FINISH, 16'h0000, 16'h0000, 16'h0000}, 1'b1,
      '{16'd466, 16'd453, RST_DEFAULT_BLUE, 1'b0, 1'b0, 1'b1, 1'b0}},
    // empty low frame reads as mean zero, red and blue quotients land on exact halves
    '{'{ACT_HIGH,   16'd254,  16'd254,  16'd254},  1'b0, NO_TYPED},
    '{'{ACT_FINISH, 16'h0000, 16'h0000, 16'h0000}, 1'b0, NO_TYPED},
    // red quotient is exactly one half and rounds down to even zero
    '{'{ACT_LOW,    16'h0000, 16'h0000, 16'h0000}, 1'b0, NO_TYPED},
    '{'{ACT_HIGH,   16'd53594, 16'd53594, 16'd53594}, 1'b0, NO_TYPED},
    '{'{ACT_FINISH, 16'h0000, 16'h0000, 16'h0000}, 1'b0, NO_TYPED},
    // two pixels per frame, most means not integral
    '{'{ACT_LOW,    16'd1000, 16'd2000, 16'd3000}, 1'b0, NO_TYPED},
    '{'{ACT_LOW,    16'd1010, 16'd2021, 16'd2987}, 1'b0, NO_TYPED},
    '{'{ACT_HIGH,   16'd1300, 16'd2100, 16'd3400}, 1'b0, NO_TYPED},
    '{'{ACT_HIGH,   16'd1299, 16'd2377, 16'd3522}, 1'b0, NO_TYPED},
    '{'{ACT_NONE,   16'h0000, 16'h0000, 16'h0000}, 1'b0, NO_TYPED},
    '{'{ACT_FINISH, 16'h0000, 16'h0000, 16'h0000}, 1'b0, NO_TYPED},
    // alternating bit patterns on the red and green samples
    '{'{ACT_LOW,    16'h5555, 16'hAAAA, 16'h1234}, 1'b0, NO_TYPED},
    '{'{ACT_HIGH,   16'hAAAA, 16'h5555, 16'hEDCB}, 1'b0, NO_TYPED},
    '{'{ACT_FINISH, 16'hFFFF, 16'h0000, 16'hFFFF}, 1'b0, NO_TYPED}
  };

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  in_item_t              in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_item_t             out_data_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [REG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  // predictor copy of the registers and accumulators
  logic [MARGIN_W-1:0] margin_q [NUM_CH];
  logic [CODE_W-1:0]   dflt_q   [NUM_CH];
  logic [SUM_W-1:0]    lo_sum   [NUM_CH];
  logic [SUM_W-1:0]    hi_sum   [NUM_CH];
  logic [CNT_W-1:0]    lo_cnt;
  logic [CNT_W-1:0]    hi_cnt;
  logic                dropped_q;

  // offset results computed at finish, waiting for their beat
  out_item_t pending_offsets [$];

  int unsigned cycle_count       = 0;
  int unsigned mismatches        = 0;
  int unsigned beats_taken       = 0;
  int unsigned offsets_seen      = 0;
  int unsigned dropped_pixels    = 0;
  int unsigned fallback_channels = 0;
  int unsigned reg_writes        = 0;
  int unsigned long_holds        = 0;
  logic        quiet_mode        = 1'b0;
  logic        hold_off_req      = 1'b0;

  dark_offset_calibration u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // gap lengths: mostly none, some short, a few long
  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (quiet_mode || roll < 70) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic void clear_frames();
    for (int c = 0; c < NUM_CH; c++) begin
      lo_sum[c] = '0;
      hi_sum[c] = '0;
    end
    lo_cnt    = '0;
    hi_cnt    = '0;
    dropped_q = 1'b0;
  endfunction

  // {fallback, code} of one channel, exact two-point arithmetic
  function automatic logic [CODE_W:0] offset_for_channel(input int c);
    logic [63:0] sl, sh, nl, nh, p, pos, neg, d, num, q, r;
    sl = 64'(lo_sum[c]);
    sh = 64'(hi_sum[c]);
    nl = 64'(lo_cnt);
    nh = 64'(hi_cnt);
    // an empty frame stands for mean zero
    if (nl == 0) begin
      sl = 0;
      nl = 1;
    end
    if (nh == 0) begin
      sh = 0;
      nh = 1;
    end
    p   = nl * nh;
    pos = sh * nl;
    neg = sl * nh;
    // slope below one: D < 127 * P
    if (pos < neg + 64'(SPAN) * p) return {1'b1, dflt_q[c]};
    d   = pos - neg;
    num = 64'(margin_q[c]) * 64'(SPAN) * p;
    q   = num / d;
    r   = num % d;
    // round half to even
    if (2 * r > d || (2 * r == d && q[0])) q = q + 1;
    q = q + 64'(BRACKET_HI);
    if (q > 64'hFFFF) q = 64'hFFFF;
    return {1'b0, q[CODE_W-1:0]};
  endfunction

  // update the accumulators with one accepted beat, queue the result on finish
  function automatic void calibrate_beat(input in_item_t b, input logic typed,
                                         input out_item_t want);
    logic [PIX_W-1:0]  px [NUM_CH];
    logic [CODE_W:0]   ch [NUM_CH];
    out_item_t         res;
    px[0] = b.red;
    px[1] = b.green;
    px[2] = b.blue;
    case (b.action)
      ACT_LOW: begin
        if (lo_cnt >= MAX_PIXELS) begin
          dropped_q = 1'b1;
          dropped_pixels++;
        end else begin
          for (int c = 0; c < NUM_CH; c++) lo_sum[c] += SUM_W'(px[c]);
          lo_cnt++;
        end
      end
      ACT_HIGH: begin
        if (hi_cnt >= MAX_PIXELS) begin
          dropped_q = 1'b1;
          dropped_pixels++;
        end else begin
          for (int c = 0; c < NUM_CH; c++) hi_sum[c] += SUM_W'(px[c]);
          hi_cnt++;
        end
      end
      ACT_FINISH: begin
        for (int c = 0; c < NUM_CH; c++) ch[c] = offset_for_channel(c);
        res.code_red       = ch[0][CODE_W-1:0];
        res.code_green     = ch[1][CODE_W-1:0];
        res.code_blue      = ch[2][CODE_W-1:0];
        res.fallback_red   = ch[0][CODE_W];
        res.fallback_green = ch[1][CODE_W];
        res.fallback_blue  = ch[2][CODE_W];
        res.overflow       = dropped_q;
        fallback_channels += res.fallback_red + res.fallback_green + res.fallback_blue;
        pending_offsets.insert(pending_offsets.size(), typed ? want : res);
        clear_frames();
      end
      default: ;
    endcase
  endfunction

  // offer one beat after a random gap, hold it until the block takes it
  task automatic drive_beat(input in_item_t b, input logic typed = 1'b0,
                            input out_item_t want = '0);
    int unsigned gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (b.action != ACT_NONE) beats_taken++;
    calibrate_beat(b, typed, want);
  endtask

  task automatic finish_calibration();
    drive_beat('{ACT_FINISH, 16'($urandom), 16'($urandom), 16'($urandom)});
  endtask

  // a run of pixels of one frame with samples drawn from a range
  task automatic fill_frame(input logic [1:0] act, input int unsigned count,
                            input int unsigned lo, input int unsigned hi);
    in_item_t b;
    for (int unsigned k = 0; k < count; k++) begin
      b.action = act;
      b.red    = 16'($urandom_range(hi, lo));
      b.green  = 16'($urandom_range(hi, lo));
      b.blue   = 16'($urandom_range(hi, lo));
      drive_beat(b);
    end
  endtask

  // one calibration: two noisy frames around a per-channel level and rise, then finish;
  // some are broken (random samples, missing finish) and a few beats are unused actions
  task automatic run_calibration();
    int unsigned      shape, n_lo, n_hi, jitter;
    int               base [NUM_CH];
    int               rise [NUM_CH];
    int               v;
    logic             is_hi;
    logic [PIX_W-1:0] px [NUM_CH];
    in_item_t         b;
    shape  = $urandom_range(0, 19);
    n_lo   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 80) : $urandom_range(0, 8);
    n_hi   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 80) : $urandom_range(0, 8);
    jitter = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2000) : $urandom_range(0, 40);
    for (int c = 0; c < NUM_CH; c++) begin
      base[c] = int'($urandom_range(0, 50000));
      // mostly slope at or above one, some right around one
      rise[c] = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 200))
                                            : int'($urandom_range(127, 4000));
      if (shape == 1) rise[c] = -int'($urandom_range(0, 3000));
    end
    while (n_lo + n_hi > 0) begin
      if ($urandom_range(0, 31) == 0) begin
        drive_beat('{ACT_NONE, 16'($urandom), 16'($urandom), 16'($urandom)});
      end
      is_hi = (n_lo == 0) || (n_hi > 0 && $urandom_range(0, 1) == 1);
      for (int c = 0; c < NUM_CH; c++) begin
        v     = base[c] + (is_hi ? rise[c] : 0) + int'($urandom_range(0, jitter));
        px[c] = (v < 0) ? '0 : (v > 65535) ? 16'hFFFF : v[PIX_W-1:0];
        // broken sequence: samples anywhere in range
        if (shape == 0) px[c] = 16'($urandom);
      end
      b.action = is_hi ? ACT_HIGH : ACT_LOW;
      b.red    = px[0];
      b.green  = px[1];
      b.blue   = px[2];
      drive_beat(b);
      if (is_hi) n_hi--;
      else n_lo--;
    end
    // now and then the frames carry over into the next calibration
    if (shape != 19) finish_calibration();
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    // margins keep their low 12 bits, indexes past the map do nothing
    if (idx <= REG_MARGIN_BLUE) begin
      margin_q[idx] = data[MARGIN_W-1:0];
    end else if (idx <= REG_DEFAULT_BLUE) begin
      dflt_q[idx - REG_DEFAULT_RED] = data;
    end
    reg_writes++;
  endtask

  // let every result drain and the sequencer settle before touching registers
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_offsets.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cmp_field(input string name, input logic [CODE_W-1:0] want,
                           input logic [CODE_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_offsets(input out_item_t got);
    out_item_t want;
    if (pending_offsets.size() == 0) begin
      $error("result beat with no finish pending");
      mismatches++;
    end else begin
      want = pending_offsets.pop_front();
      cmp_field("code_red",       want.code_red,       got.code_red);
      cmp_field("code_green",     want.code_green,     got.code_green);
      cmp_field("code_blue",      want.code_blue,      got.code_blue);
      cmp_field("fallback_red",   16'(want.fallback_red),   16'(got.fallback_red));
      cmp_field("fallback_green", 16'(want.fallback_green), 16'(got.fallback_green));
      cmp_field("fallback_blue",  16'(want.fallback_blue),  16'(got.fallback_blue));
      cmp_field("overflow",       16'(want.overflow),       16'(got.overflow));
    end
    offsets_seen++;
  endtask

  // result side: checks every beat and stalls at random, once for a long stretch
  initial begin : result_side
    int unsigned stall_left;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) check_offsets(out_data_o);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = HOLD_CYCLES;
        long_holds++;
      end else if (stall_left == 0) begin
        stall_left = idle_len();
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_count, pending_offsets.size());
    $display("[dark_offset_calibration] ERROR");
    $finish;
  end

  initial begin : stimulus
    int unsigned           phase_goal;
    logic [CFG_DATA_W-1:0] val;
    margin_q[0] = RST_MARGIN_RED;
    margin_q[1] = RST_MARGIN_GREEN;
    margin_q[2] = RST_MARGIN_BLUE;
    dflt_q[0]   = RST_DEFAULT_RED;
    dflt_q[1]   = RST_DEFAULT_GREEN;
    dflt_q[2]   = RST_DEFAULT_BLUE;
    clear_frames();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows under reset register values
    for (int i = 0; i < $size(DIRECTED); i++) begin
      drive_beat(DIRECTED[i].beat, DIRECTED[i].typed, DIRECTED[i].want);
    end
    drain();

    // capacity: both frames overflow, the high one held full of full-scale pixels
    quiet_mode = 1'b1;
    fill_frame(ACT_LOW, MAX_PIXELS + 3, 0, 255);
    fill_frame(ACT_HIGH, MAX_PIXELS + 2, 65535, 65535);
    finish_calibration();
    quiet_mode = 1'b0;
    drain();

    // random calibrations, one register setting per phase
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        for (int r = REG_MARGIN_RED; r <= REG_DEFAULT_BLUE; r++) begin
          case (ph)
            1: val = 16'hFFFF;  // margins mask down to 4095
            2: val = '0;
            NUM_PHASES - 1: val = (r <= REG_MARGIN_BLUE) ? 16'd1 : 16'($urandom);
            default: val = 16'($urandom);
          endcase
          write_reg(REG_IDX_W'(r), val);
        end
        if (ph == 1) begin
          write_reg(REG_UNUSED_LO, 16'($urandom));
          write_reg(REG_UNUSED_HI, 16'($urandom));
        end
        cfg_valid_i <= 1'b0;
        @(posedge clk_i);
      end
      // output held off long enough that a second finish backs up the input
      if (ph == 2) hold_off_req = 1'b1;
      quiet_mode = (ph == NUM_PHASES - 1);
      phase_goal = beats_taken + RANDOM_BEATS / NUM_PHASES;
      while (beats_taken < phase_goal) run_calibration();
      finish_calibration();
      drain();
    end

    $display("covered %0d pixel and finish beats, %0d offset results, %0d channel fallbacks,",
             beats_taken, offsets_seen, fallback_channels);
    $display("%0d dropped pixels, %0d register writes, %0d long output hold-offs, %0d cycles",
             dropped_pixels, reg_writes, long_holds, cycle_count);
    if (mismatches == 0) begin
      $display("[dark_offset_calibration] OK");
    end else begin
      $display("[dark_offset_calibration] ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
src/dkoc_pkg.sv
src/dkoc_ctrl.sv
src/dkoc_datapath.sv
src/dark_offset_calibration.sv
verif/tb_dark_offset_calibration.sv
